@@ hw/rtl/chms_pkg.sv @@
// Package for the pair-cell heap core: sizes, action codes, cell record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chms_pkg;
  localparam int CellCount = 1024;
  localparam int ValueBits = 32;
  localparam int IdxBits   = $clog2(CellCount);
  localparam int SweepBits = IdxBits + 1;
  localparam int ClrCycles = CellCount;

  localparam logic [ValueBits-1:0] NullValue = '1;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_ALLOC = 2'd2,
    ACT_MARK  = 2'd3
  } action_t;

  // One memory word: both halves, their pointer flags, mark and reversal bits.
  typedef struct packed {
    logic [ValueBits-1:0] fv;
    logic                 fp;
    logic [ValueBits-1:0] sv;
    logic                 sp;
    logic                 mark;
    logic                 rev;
  } cell_t;
endpackage
`default_nettype wire

@@ hw/rtl/cons_heap_mark_and_lazy_sweep_core.sv @@
// Pair-cell heap core: reads, writes, lazy-sweep allocate, pointer-reversal mark.
// Depends on chms_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Command channel: a request is taken on a rising edge with start high and
//   busy low. action selects read, write, allocate or mark; the other fields
//   carry the cell index, the two halves and their pointer flags (first_value
//   and first_is_pointer are the root for mark).
//   Every request yields exactly one result, shown for one cycle with done
//   high. The receiver cannot stall; it must take the result when done pulses.
//   Memory: all cell state (halves, flags, mark and reversal bits) lives in
//   one single-port memory with a registered read; each step is one access.
//   A write is a read-modify-write that keeps the mark bits. Allocate sweeps
//   cells, clearing the marks of marked ones, until it hands out an unmarked
//   one; a full heap raises heap_full. Mark marks a cell, switches it to its
//   second half and retreats from it, and refuses each pointer that is not in
//   the store or names a marked cell; an atomic root needs no memory write.
//   busy stays high until the result cycle, in which the next request may be
//   taken, so items run strictly one after another.
//   Reset: after rst the core runs a clearing pass over all CellCount (1024)
//   cells that writes the reset image into the memory; busy is high meanwhile.
module cons_heap_mark_and_lazy_sweep_core
  import chms_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           action,
  input  wire logic [IdxBits-1:0]   cell_index,
  input  wire logic [ValueBits-1:0] first_value,
  input  wire logic                 first_is_pointer,
  input  wire logic [ValueBits-1:0] second_value,
  input  wire logic                 second_is_pointer,
  output logic                      done,
  output logic [ValueBits-1:0]      read_first,
  output logic                      read_first_pointer,
  output logic [ValueBits-1:0]      read_second,
  output logic                      read_second_pointer,
  output logic [IdxBits-1:0]        allocated_index,
  output logic                      heap_full
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_RDW   = 12'b000000001000,
    S_AL    = 12'b000000010000,
    S_DSC   = 12'b000000100000,
    S_DSCW  = 12'b000001000000,
    S_RET   = 12'b000010000000,
    S_RETW  = 12'b000100000000,
    S_WR    = 12'b001000000000,
    S_ALW   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state;

  // Cell memory, registered read.
  cell_t mem [CellCount];
  cell_t rdata;
  logic               mem_we;
  logic [IdxBits-1:0] mem_addr;
  cell_t              mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[mem_addr];
  end

  // Request and walk registers.
  logic [IdxBits-1:0]   idx;
  logic [ValueBits-1:0] fv;
  logic                 fp;
  logic [ValueBits-1:0] sv;
  logic                 sp;
  logic [SweepBits-1:0] sweep;
  logic [IdxBits-1:0]   clr;

  // Traversal registers: current value, previous cell, root.
  logic [ValueBits-1:0] cv;
  logic                 cp;
  logic [IdxBits-1:0]   pv;
  logic                 pnull;
  logic [IdxBits-1:0]   root;

  // True when a value names a cell inside the store.
  function automatic logic in_store(input logic [ValueBits-1:0] v);
    return v < ValueBits'(CellCount);
  endfunction

  // Candidate for descent; the mark bit is checked once the word is read.
  logic cv_ok;
  assign cv_ok = cp && in_store(cv);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pv;
    mem_wdata = rdata;
    unique case (state)
      S_CLEAR: begin
        mem_we         = 1'b1;
        mem_addr       = clr;
        mem_wdata.fv   = '0;
        mem_wdata.fp   = 1'b0;
        mem_wdata.sv   = (clr == IdxBits'(CellCount - 1)) ? NullValue
                         : ValueBits'(clr) + ValueBits'(1);
        mem_wdata.sp   = 1'b1;
        mem_wdata.mark = 1'b0;
        mem_wdata.rev  = 1'b0;
      end
      S_IDLE: mem_addr = cell_index;
      S_WR: begin
        // keep mark and reversal bits, replace halves and flags
        mem_addr     = idx;
        mem_we       = 1'b1;
        mem_wdata.fv = fv;
        mem_wdata.fp = fp;
        mem_wdata.sv = sv;
        mem_wdata.sp = sp;
      end
      S_AL:  mem_addr = sweep[IdxBits-1:0];
      S_ALW: begin
        mem_addr = sweep[IdxBits-1:0];
        mem_we   = 1'b1;
        if (rdata.mark) mem_wdata.mark = 1'b0;
        else mem_wdata = '0;
      end
      S_RD:   mem_addr = idx;
      S_DSC:  mem_addr = cv[IdxBits-1:0];
      S_DSCW: begin
        mem_addr       = idx;
        mem_we         = !rdata.mark;
        mem_wdata.fv   = pnull ? NullValue : ValueBits'(pv);
        mem_wdata.fp   = 1'b1;
        mem_wdata.mark = 1'b1;
      end
      S_RETW: begin
        mem_addr = pv;
        mem_we   = 1'b1;
        if (rdata.rev) begin
          // retreat: restore second half
          mem_wdata.sv  = cv;
          mem_wdata.sp  = cp;
          mem_wdata.rev = 1'b0;
        end else begin
          // switch: restore first half, park parent link in second half
          mem_wdata.fv  = cv;
          mem_wdata.fp  = cp;
          mem_wdata.sv  = rdata.fv;
          mem_wdata.sp  = rdata.fp;
          mem_wdata.rev = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      unique case (state)
        S_CLEAR: begin
          clr <= clr + IdxBits'(1);
          if (clr == IdxBits'(CellCount - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          idx <= cell_index;
          fv <= first_value; fp <= first_is_pointer;
          sv <= second_value; sp <= second_is_pointer;
          read_first <= '0; read_first_pointer <= 1'b0;
          read_second <= '0; read_second_pointer <= 1'b0;
          allocated_index <= '0; heap_full <= 1'b0;
          unique case (action_t'(action))
            ACT_READ:  state <= S_RD;
            ACT_WRITE: state <= S_WR;
            ACT_ALLOC: state <= S_AL;
            ACT_MARK: begin
              cv    <= first_value;
              cp    <= first_is_pointer;
              pnull <= 1'b1;
              root  <= first_value[IdxBits-1:0];
              state <= S_DSC;
            end
            default: state <= S_DONE;
          endcase
        end
        S_RD:  state <= S_RDW;
        S_RDW: begin
          read_first <= rdata.fv; read_first_pointer <= rdata.fp;
          read_second <= rdata.sv; read_second_pointer <= rdata.sp;
          state <= S_DONE;
        end
        S_WR: state <= S_DONE;
        S_AL: begin
          if (sweep[IdxBits]) begin
            sweep     <= '0;
            heap_full <= 1'b1;
            state     <= S_DONE;
          end else begin
            state <= S_ALW;
          end
        end
        // Marked cell: mark cleared, keep sweeping; else hand it out.
        S_ALW: begin
          sweep <= sweep + SweepBits'(1);
          if (rdata.mark) begin
            state <= S_AL;
          end else begin
            allocated_index <= sweep[IdxBits-1:0];
            state <= S_DONE;
          end
        end
        // Descend: fetch cell cv, mark it if not yet marked.
        S_DSC: begin
          if (cv_ok) begin
            idx   <= cv[IdxBits-1:0];
            state <= S_DSCW;
          end else begin
            state <= S_RET;
          end
        end
        S_DSCW: begin
          if (rdata.mark) begin
            state <= S_RET;
          end else begin
            pv    <= idx;
            pnull <= 1'b0;
            cv    <= rdata.fv;
            cp    <= rdata.fp;
            state <= S_DSC;
          end
        end
        // Retreat or switch, decided on the previous cell's reversal bit.
        S_RET: begin
          if (pnull) state <= S_DONE;
          else state <= S_RETW;
        end
        S_RETW: begin
          if (rdata.rev) begin
            cv <= ValueBits'(pv);
            cp <= 1'b1;
            if (pv == root || !in_store(rdata.sv)) pnull <= 1'b1;
            else pv <= rdata.sv[IdxBits-1:0];
            state <= S_RET;
          end else begin
            cv    <= rdata.sv;
            cp    <= rdata.sp;
            state <= S_DSC;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/chms_checker.sv @@
// Port-level checker for the heap core, bound to the core module.
// Depends on chms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chms_checker
  import chms_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire logic [IdxBits-1:0]   allocated_index,
  input wire logic                 heap_full,
  input wire logic [ValueBits-1:0] read_first
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("no busy after request");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than a cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_full_idx: assert property (@(posedge clk) disable iff (rst)
    done && heap_full |-> allocated_index == '0 && read_first == '0)
    else $error("full with index");
endmodule

bind cons_heap_mark_and_lazy_sweep_core chms_checker u_chms_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .allocated_index(allocated_index), .heap_full(heap_full),
  .read_first(read_first)
);
`default_nettype wire
